// File: rtl/ipt_pkg.sv
// Package for the IPv4 prefix table: opcodes, status codes, sequencer states,
// table entry and compare result types. No dependencies.
`default_nettype none

package ipt_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned TagW  = 16;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_EXACT  = 2'd1,
    OP_ADD    = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXISTS    = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PLACE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] mask;
    logic [TagW-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic prefix_hit;
    logic exact_hit;
    logic mask_greater;
  } cmp_t;

endpackage

`default_nettype wire

// File: rtl/ipt_req_if.sv
// Request channel of the IPv4 prefix table: valid/ready plus request payload.
// No dependencies.
`default_nettype none

interface ipt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] address;
  logic [31:0] prefix_mask;
  logic [15:0] entry_tag_in;

  modport source (output valid, opcode, address, prefix_mask, entry_tag_in, input ready);
  modport sink   (input valid, opcode, address, prefix_mask, entry_tag_in, output ready);
endinterface

`default_nettype wire

// File: rtl/ipt_rsp_if.sv
// Response channel of the IPv4 prefix table: valid/ready plus status and tag.
// No dependencies.
`default_nettype none

interface ipt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] entry_tag_out;

  modport source (output valid, status, entry_tag_out, input ready);
  modport sink   (input valid, status, entry_tag_out, output ready);
endinterface

`default_nettype wire

// File: rtl/ipv4_prefix_table.sv
// IPv4 longest-prefix table: sequencer, entry memory and response register.
// Depends on ipt_pkg, ipt_req_if, ipt_rsp_if and ipt_entry_cmp.
//
// Usage:
//   req_i carries opcode (lookup, exact search, add, remove), address,
//   prefix_mask and entry_tag_in; rsp_o returns status and entry_tag_out.
//   A transaction completes when valid and ready are both high.
//   Entries sit in a single-port-write, single-port-read memory ordered by
//   mask, largest first. One compare unit walks it one entry per cycle.
//   Steps, with p the hit or insert position:
//     lookup / exact search: scan until the first hit, then respond.
//     add: full scan, then move the entries from p on down one place, then place.
//     remove: scan to the hit at p, then move the tail up one place.
//   req_i.ready is high only while the sequencer is idle, one request at a time.
//   A finished response waits in the output register; a stalled receiver
//   holds the sequencer in its response state, but the next request can
//   be accepted as soon as the earlier response is registered.
//   Reset empties the table (entry count to zero); memory contents are not
//   cleared, and contents beyond the entry count are never used.
`default_nettype none

module ipv4_prefix_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ipt_req_if.sink    req_i,
  ipt_rsp_if.source  rsp_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  ipt_pkg::entry_t mem [TABLE_ENTRIES];

  ipt_pkg::state_e  state_q, state_d;
  ipt_pkg::opcode_e op_q, op_d;
  logic [ipt_pkg::AddrW-1:0] addr_q, addr_d, mask_q, mask_d;
  logic [ipt_pkg::TagW-1:0]  tagin_q, tagin_d;
  logic [CW-1:0] idx_q, idx_d, pos_q, pos_d, count_q, count_d;
  logic pm_found_q, pm_found_d, pos_found_q, pos_found_d;
  ipt_pkg::status_e res_status_q, res_status_d;
  logic [ipt_pkg::TagW-1:0] res_tag_q, res_tag_d;
  logic out_valid_q, out_valid_d;
  ipt_pkg::status_e out_status_q, out_status_d;
  logic [ipt_pkg::TagW-1:0] out_tag_q, out_tag_d;

  ipt_pkg::entry_t rd_data_q;
  logic [CW-1:0]   rd_addr_cw, wr_addr_cw, pos_v;
  logic            we;
  ipt_pkg::entry_t wr_data;
  ipt_pkg::cmp_t   cmp;

  ipt_entry_cmp u_cmp (
    .address_i (addr_q),
    .mask_i    (mask_q),
    .entry_i   (rd_data_q),
    .cmp_o     (cmp)
  );

  assign req_i.ready         = (state_q == ipt_pkg::S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.entry_tag_out = out_tag_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    addr_d       = addr_q;
    mask_d       = mask_q;
    tagin_d      = tagin_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    count_d      = count_q;
    pm_found_d   = pm_found_q;
    pos_found_d  = pos_found_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_tag_d    = out_tag_q;
    rd_addr_cw   = idx_q + CW'(1);
    wr_addr_cw   = idx_q;
    wr_data      = rd_data_q;
    we           = 1'b0;
    pos_v        = pos_found_q ? pos_q : count_q;

    unique case (state_q)
      ipt_pkg::S_IDLE: begin
        rd_addr_cw = '0;
        if (req_i.valid) begin
          op_d        = ipt_pkg::opcode_e'(req_i.opcode);
          addr_d      = req_i.address;
          mask_d      = req_i.prefix_mask;
          tagin_d     = req_i.entry_tag_in;
          idx_d       = '0;
          pm_found_d  = 1'b0;
          pos_found_d = 1'b0;
          state_d     = ipt_pkg::S_SCAN;
        end
      end

      ipt_pkg::S_SCAN: begin
        if (idx_q == count_q) begin
          res_tag_d = '0;
          if (op_q != ipt_pkg::OP_ADD) begin
            res_status_d = ipt_pkg::STATUS_NOT_FOUND;
            state_d      = ipt_pkg::S_RESP;
          end else if (count_q == CW'(TABLE_ENTRIES)) begin
            res_status_d = ipt_pkg::STATUS_FULL;
            state_d      = ipt_pkg::S_RESP;
          end else begin
            pos_d = pos_v;
            if (pos_v == count_q) begin
              state_d = ipt_pkg::S_PLACE;
            end else begin
              idx_d      = count_q;
              rd_addr_cw = count_q - CW'(1);
              state_d    = ipt_pkg::S_SHIFT_DN;
            end
          end
        end else begin
          idx_d = idx_q + CW'(1);
          unique case (op_q)
            ipt_pkg::OP_LOOKUP: begin
              if (cmp.prefix_hit) begin
                res_status_d = ipt_pkg::STATUS_OK;
                res_tag_d    = rd_data_q.tag;
                state_d      = ipt_pkg::S_RESP;
              end
            end
            ipt_pkg::OP_EXACT: begin
              if (cmp.exact_hit) begin
                res_status_d = ipt_pkg::STATUS_OK;
                res_tag_d    = rd_data_q.tag;
                state_d      = ipt_pkg::S_RESP;
              end
            end
            ipt_pkg::OP_REMOVE: begin
              if (cmp.exact_hit) begin
                res_status_d = ipt_pkg::STATUS_OK;
                res_tag_d    = rd_data_q.tag;
                idx_d        = idx_q;
                state_d      = ipt_pkg::S_SHIFT_UP;
              end
            end
            ipt_pkg::OP_ADD: begin
              // only the first prefix hit counts for the duplicate check
              if (!pm_found_q && cmp.prefix_hit) begin
                pm_found_d = 1'b1;
                if (cmp.exact_hit) begin
                  res_status_d = ipt_pkg::STATUS_EXISTS;
                  res_tag_d    = '0;
                  state_d      = ipt_pkg::S_RESP;
                end
              end
              if (!pos_found_q && cmp.mask_greater) begin
                pos_found_d = 1'b1;
                pos_d       = idx_q;
              end
            end
          endcase
        end
      end

      ipt_pkg::S_SHIFT_UP: begin
        // rd_data_q holds entry idx_q + 1
        if ((idx_q + CW'(1)) < count_q) begin
          we         = 1'b1;
          wr_addr_cw = idx_q;
          idx_d      = idx_q + CW'(1);
          rd_addr_cw = idx_q + CW'(2);
        end else begin
          count_d = count_q - CW'(1);
          state_d = ipt_pkg::S_RESP;
        end
      end

      ipt_pkg::S_SHIFT_DN: begin
        // rd_data_q holds entry idx_q - 1
        we         = 1'b1;
        wr_addr_cw = idx_q;
        if ((idx_q - CW'(1)) == pos_q) begin
          state_d = ipt_pkg::S_PLACE;
        end else begin
          idx_d      = idx_q - CW'(1);
          rd_addr_cw = idx_q - CW'(2);
        end
      end

      ipt_pkg::S_PLACE: begin
        we           = 1'b1;
        wr_addr_cw   = pos_q;
        wr_data      = '{address: addr_q, mask: mask_q, tag: tagin_q};
        count_d      = count_q + CW'(1);
        res_status_d = ipt_pkg::STATUS_OK;
        res_tag_d    = '0;
        state_d      = ipt_pkg::S_RESP;
      end

      ipt_pkg::S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_tag_d    = res_tag_q;
          state_d      = ipt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ipt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipt_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    addr_q       <= addr_d;
    mask_q       <= mask_d;
    tagin_q      <= tagin_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    pm_found_q   <= pm_found_d;
    pos_found_q  <= pos_found_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    out_status_q <= out_status_d;
    out_tag_q    <= out_tag_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr_cw[IW-1:0]] <= wr_data;
    end
    rd_data_q <= mem[rd_addr_cw[IW-1:0]];
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == ipt_pkg::S_SCAN))
    else $error("accepted transaction did not start a scan");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == ipt_pkg::S_PLACE ||
                           $past(state_q) == ipt_pkg::S_SHIFT_UP))
    else $error("entry count changed outside insert or remove");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (wr_addr_cw <= count_q && count_q < CW'(TABLE_ENTRIES + 1)))
    else $error("table write beyond the occupied range");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ipt_pkg::S_RESP))
    else $error("response raised outside response state");

endmodule

`default_nettype wire

// File: rtl/ipt_entry_cmp.sv
// Shared compare unit: checks one table entry against the held request.
// Depends on ipt_pkg.
`default_nettype none

module ipt_entry_cmp (
  input  logic [ipt_pkg::AddrW-1:0] address_i,
  input  logic [ipt_pkg::AddrW-1:0] mask_i,
  input  ipt_pkg::entry_t           entry_i,
  output ipt_pkg::cmp_t             cmp_o
);

  always_comb begin
    cmp_o.prefix_hit   = (address_i & entry_i.mask) == entry_i.address;
    cmp_o.exact_hit    = (address_i == entry_i.address) && (mask_i == entry_i.mask);
    cmp_o.mask_greater = mask_i > entry_i.mask;
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for ipv4_prefix_table: drives request transactions and checks each
// response against an in-bench model of the ordered prefix table.
// Depends on ipt_pkg, ipt_req_if, ipt_rsp_if and the ipv4_prefix_table RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned N_ITEMS      = 950;
  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned MAX_REPORTS  = 30;

  typedef struct packed {
    ipt_pkg::opcode_e op;
    logic [31:0]      address;
    logic [31:0]      mask;
    logic [15:0]      tag;
  } request_t;

  typedef struct packed {
    ipt_pkg::status_e status;
    logic [15:0]      tag;
  } reply_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] mask;
  } prefix_t;

  logic clk;
  logic rst_n;

  ipt_req_if req ();
  ipt_rsp_if rsp ();

  ipv4_prefix_table #(
    .TABLE_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  request_t    pending_requests[$];
  reply_t      expected_replies[$];
  prefix_t     added_prefixes[$];

  // shadow of the prefix table
  logic [31:0] tbl_addr[TABLE_DEPTH];
  logic [31:0] tbl_mask[TABLE_DEPTH];
  logic [15:0] tbl_tag[TABLE_DEPTH];
  int unsigned tbl_count;

  int unsigned n_by_op[4];
  int unsigned n_by_status[4];
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_replies;
  int unsigned n_cycles;

  bit          offering;
  int unsigned tx_gap;
  bit          rx_ready;
  int unsigned rx_stall;
  logic        rx_hold;
  int unsigned hold_cnt;
  reply_t      want;

  function automatic int unsigned first_prefix_hit(logic [31:0] a);
    for (int unsigned i = 0; i < tbl_count; i++)
      if ((a & tbl_mask[i]) == tbl_addr[i]) return i;
    return tbl_count;
  endfunction

  function automatic int unsigned first_exact_hit(logic [31:0] a, logic [31:0] m);
    for (int unsigned i = 0; i < tbl_count; i++)
      if (tbl_addr[i] == a && tbl_mask[i] == m) return i;
    return tbl_count;
  endfunction

  function automatic reply_t table_update(request_t r);
    reply_t      rep;
    int unsigned pos;
    rep.status = ipt_pkg::STATUS_NOT_FOUND;
    rep.tag    = '0;
    case (r.op)
      ipt_pkg::OP_LOOKUP: begin
        pos = first_prefix_hit(r.address);
        if (pos < tbl_count) begin
          rep.status = ipt_pkg::STATUS_OK;
          rep.tag    = tbl_tag[pos];
        end
      end
      ipt_pkg::OP_EXACT: begin
        pos = first_exact_hit(r.address, r.mask);
        if (pos < tbl_count) begin
          rep.status = ipt_pkg::STATUS_OK;
          rep.tag    = tbl_tag[pos];
        end
      end
      ipt_pkg::OP_ADD: begin
        pos = first_prefix_hit(r.address);
        if (pos < tbl_count && tbl_addr[pos] == r.address && tbl_mask[pos] == r.mask) begin
          rep.status = ipt_pkg::STATUS_EXISTS;
        end else if (tbl_count >= TABLE_DEPTH) begin
          rep.status = ipt_pkg::STATUS_FULL;
        end else begin
          // goes after every entry with an equal or larger mask
          pos = 0;
          while (pos < tbl_count && !(r.mask > tbl_mask[pos])) pos++;
          for (int unsigned j = tbl_count; j > pos; j--) begin
            tbl_addr[j] = tbl_addr[j-1];
            tbl_mask[j] = tbl_mask[j-1];
            tbl_tag[j]  = tbl_tag[j-1];
          end
          tbl_addr[pos] = r.address;
          tbl_mask[pos] = r.mask;
          tbl_tag[pos]  = r.tag;
          tbl_count++;
          rep.status = ipt_pkg::STATUS_OK;
        end
      end
      default: begin
        pos = first_exact_hit(r.address, r.mask);
        if (pos < tbl_count) begin
          rep.tag = tbl_tag[pos];
          for (int unsigned j = pos; j + 1 < tbl_count; j++) begin
            tbl_addr[j] = tbl_addr[j+1];
            tbl_mask[j] = tbl_mask[j+1];
            tbl_tag[j]  = tbl_tag[j+1];
          end
          tbl_count--;
          rep.status = ipt_pkg::STATUS_OK;
        end
      end
    endcase
    n_by_op[r.op]++;
    n_by_status[rep.status]++;
    return rep;
  endfunction

  task automatic push_req(ipt_pkg::opcode_e op, logic [31:0] a, logic [31:0] m,
                          logic [15:0] t);
    request_t r;
    prefix_t  p;
    r.op      = op;
    r.address = a;
    r.mask    = m;
    r.tag     = t;
    pending_requests.push_back(r);
    if (op == ipt_pkg::OP_ADD) begin
      p.base = a;
      p.mask = m;
      added_prefixes.push_back(p);
    end
  endtask

  // one remove per add ever issued, in random order, leaves the table empty
  task automatic drain_table();
    int unsigned k;
    while (added_prefixes.size() > 0) begin
      k = $urandom_range(0, added_prefixes.size() - 1);
      push_req(ipt_pkg::OP_REMOVE, added_prefixes[k].base, added_prefixes[k].mask,
               16'($urandom));
      added_prefixes.delete(k);
    end
  endtask

  function automatic prefix_t random_prefix(prefix_t parent, bit has_parent);
    prefix_t     p;
    int unsigned len;
    int unsigned kind;
    kind   = $urandom_range(0, 99);
    len    = $urandom_range(0, 32);
    p.mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    if (has_parent && kind < 20) p.mask = parent.mask;
    else if (kind >= 90) p.mask = $urandom;
    p.base = $urandom & p.mask;
    if (has_parent && kind >= 20 && kind < 50) begin
      // nested under the parent prefix
      p.mask = p.mask | parent.mask;
      p.base = (parent.base & parent.mask) | ($urandom & p.mask & ~parent.mask);
    end
    if (kind >= 80 && kind < 90) p.base = $urandom;
    return p;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    prefix_t     pool[$];
    prefix_t     p;
    prefix_t     none;
    int unsigned pool_size;
    int unsigned sel;

    req.valid        = 1'b0;
    req.opcode       = ipt_pkg::OP_LOOKUP;
    req.address      = '0;
    req.prefix_mask  = '0;
    req.entry_tag_in = '0;
    rsp.ready        = 1'b0;
    rst_n            = 1'b0;
    none             = '0;

    push_req(ipt_pkg::OP_LOOKUP, 32'h0A01_0203, 32'h0, 16'h0);
    push_req(ipt_pkg::OP_ADD,    32'h0A00_0000, 32'hFF00_0000, 16'h1111);
    push_req(ipt_pkg::OP_ADD,    32'h0A01_0000, 32'hFFFF_0000, 16'h2222);
    push_req(ipt_pkg::OP_ADD,    32'h0A01_0200, 32'hFFFF_FF00, 16'h3333);
    push_req(ipt_pkg::OP_LOOKUP, 32'h0A01_0203, 32'h0, 16'h0);
    push_req(ipt_pkg::OP_ADD,    32'h0A01_0200, 32'hFFFF_FF00, 16'h4444);
    push_req(ipt_pkg::OP_ADD,    32'h0A00_0000, 32'hFFFF_0000, 16'h5555);
    // duplicate of the /8 hidden behind the new /16
    push_req(ipt_pkg::OP_ADD,    32'h0A00_0000, 32'hFF00_0000, 16'h6666);
    push_req(ipt_pkg::OP_ADD,    32'hC0A8_0000, 32'hFFFF_0000, 16'h7777);
    // host bits outside the mask
    push_req(ipt_pkg::OP_ADD,    32'hAC10_0505, 32'hFFFF_0000, 16'h8888);
    push_req(ipt_pkg::OP_LOOKUP, 32'hAC10_0505, 32'h0, 16'h0);
    push_req(ipt_pkg::OP_EXACT,  32'hAC10_0505, 32'hFFFF_0000, 16'h0);
    push_req(ipt_pkg::OP_ADD,    32'h0000_0000, 32'h0000_0000, 16'h9999);
    push_req(ipt_pkg::OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_req(ipt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0);
    push_req(ipt_pkg::OP_REMOVE, 32'h0A01_0000, 32'hFFFF_0000, 16'h0);
    push_req(ipt_pkg::OP_REMOVE, 32'h0A01_0000, 32'hFFFF_0000, 16'h0);
    push_req(ipt_pkg::OP_EXACT,  32'h0A01_0200, 32'hFFFF_FFFE, 16'h0);
    for (int unsigned k = 0; k < 8; k++)
      push_req(ipt_pkg::OP_ADD, 32'hC633_6400 + k, 32'hFFFF_FFFF, 16'($urandom));
    push_req(ipt_pkg::OP_ADD, 32'h0B00_0000, 32'hFF00_0000, 16'hABCD);
    drain_table();

    while (pending_requests.size() < N_ITEMS) begin
      pool.delete();
      pool_size = $urandom_range(3, 24);
      for (int unsigned k = 0; k < pool_size; k++) begin
        if (k == 0) pool.push_back(random_prefix(none, 1'b0));
        else pool.push_back(random_prefix(pool[$urandom_range(0, k - 1)], 1'b1));
      end
      if ($urandom_range(0, 2) == 0)
        foreach (pool[k])
          push_req(ipt_pkg::OP_ADD, pool[k].base, pool[k].mask, 16'($urandom));
      repeat ($urandom_range(20, 60)) begin
        sel = $urandom_range(0, 99);
        p   = pool[$urandom_range(0, pool.size() - 1)];
        if (sel < 32) begin
          push_req(ipt_pkg::OP_ADD, p.base, p.mask, 16'($urandom));
        end else if (sel < 58) begin
          push_req(ipt_pkg::OP_LOOKUP, (p.base & p.mask) | ($urandom & ~p.mask), $urandom,
                   16'($urandom));
        end else if (sel < 62) begin
          push_req(ipt_pkg::OP_LOOKUP, $urandom, $urandom, 16'($urandom));
        end else if (sel < 73) begin
          push_req(ipt_pkg::OP_EXACT, p.base, p.mask, 16'($urandom));
        end else if (sel < 77) begin
          push_req(ipt_pkg::OP_EXACT, p.base, p.mask ^ (32'h1 << $urandom_range(0, 31)),
                   16'($urandom));
        end else if (sel < 93) begin
          push_req(ipt_pkg::OP_REMOVE, p.base, p.mask, 16'($urandom));
        end else begin
          push_req(ipt_pkg::opcode_e'($urandom_range(0, 3)), $urandom, $urandom,
                   16'($urandom));
        end
      end
      drain_table();
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || offering || expected_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d transactions: %0d lookups, %0d exact searches, %0d adds, %0d removes.",
             n_sent, n_by_op[ipt_pkg::OP_LOOKUP], n_by_op[ipt_pkg::OP_EXACT],
             n_by_op[ipt_pkg::OP_ADD], n_by_op[ipt_pkg::OP_REMOVE]);
    $display("Outcomes: %0d ok, %0d duplicate, %0d miss, %0d table full; %0d errors.",
             n_by_status[ipt_pkg::STATUS_OK], n_by_status[ipt_pkg::STATUS_EXISTS],
             n_by_status[ipt_pkg::STATUS_NOT_FOUND], n_by_status[ipt_pkg::STATUS_FULL],
             n_errors);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      offering = 1'b0;
      tx_gap   = 0;
      req.valid <= 1'b0;
    end else begin
      if (offering && req.ready) begin
        expected_replies.push_back(table_update(request_t'({req.opcode, req.address,
                                                            req.prefix_mask,
                                                            req.entry_tag_in})));
        n_sent++;
        offering = 1'b0;
        tx_gap   = ((n_sent / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
      end
      if (!offering && pending_requests.size() > 0) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else begin
          request_t r;
          r = pending_requests.pop_front();
          req.opcode       <= r.op;
          req.address      <= r.address;
          req.prefix_mask  <= r.mask;
          req.entry_tag_in <= r.tag;
          offering = 1'b1;
        end
      end
      req.valid <= offering;
    end
  end

  // response monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ready = 1'b0;
      rx_stall = 0;
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rx_ready) begin
        n_replies++;
        if (expected_replies.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: unexpected response, status %0d tag %h", $realtime,
                     rsp.status, rsp.entry_tag_out);
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status || rsp.entry_tag_out !== want.tag) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: response %0d mismatch, expected status %0d tag %h, got status %0d tag %h",
                       $realtime, n_replies, want.status, want.tag, rsp.status,
                       rsp.entry_tag_out);
          end
        end
        rx_stall = ((n_replies / 40) % 3 == 2) ? 0 : $urandom_range(0, 19);
      end
      if (rx_hold) begin
        rx_ready = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        rx_ready = 1'b0;
      end else begin
        rx_ready = 1'b1;
      end
      rsp.ready <= rx_ready;
    end
  end

  // long receiver hold-offs so requests back up behind a stalled response
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      rx_hold  <= 1'b0;
    end else begin
      hold_cnt <= hold_cnt + 1;
      rx_hold  <= (hold_cnt >= 3000 && hold_cnt < 3400) ||
                  (hold_cnt >= 12000 && hold_cnt < 12500);
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d responses outstanding", $realtime,
               n_cycles, expected_replies.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
